@@ rtl/segment_box_closest_hit_assert.svh @@
// assertion macros for segment_box_closest_hit
`ifndef SEGMENT_BOX_CLOSEST_HIT_ASSERT_SVH
`define SEGMENT_BOX_CLOSEST_HIT_ASSERT_SVH
`define SBCH_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: lbl failed");
`define SBCH_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: lbl failed");
`endif

@@ rtl/sbch_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sbch_pkg;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned IN_BITS  = 32 * 6 + 31 * 2 + 16 * 2;  // 286
  localparam int unsigned IN_BYTES = (IN_BITS + 7) / 8;
  localparam int unsigned IN_W     = IN_BYTES * 8;
  localparam int unsigned OUT_BITS = 16 + 16 + 3 + 32 + 32 + 34;  // 133
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [2:0] NRM_NONE = 3'd0;
  localparam logic [2:0] NRM_NX   = 3'd1;
  localparam logic [2:0] NRM_PX   = 3'd2;
  localparam logic [2:0] NRM_NY   = 3'd3;
  localparam logic [2:0] NRM_PY   = 3'd4;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SLAB_X, OP_SLAB_Y, OP_DIV, OP_TN, OP_TF, OP_CHECK,
    OP_MUL, OP_SQRT, OP_COMMIT, OP_EMIT, OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       axis;   // 0 x, 1 y
    logic       far;    // 0 near parameter, 1 far parameter
  } cmd_t;

  typedef struct packed {
    logic skip;     // zero length or ignored box
    logic par;      // current axis direction is zero
    logic par_miss; // parallel and outside slab
    logic neg_num;  // quotient numerator negative
    logic div_done;
    logic miss;     // entry beyond exit
    logic better;   // fits and below best
    logic sqrt_done;
    logic last;
  } sts_t;
endpackage
`default_nettype wire

@@ rtl/sbch_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sbch_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire sbch_pkg::sts_t sts_i,
  output sbch_pkg::cmd_t      cmd_o
);
  localparam logic [3:0] S_IDLE = 4'd0, S_LOAD = 4'd1, S_SLAB = 4'd2, S_DIVS = 4'd3,
                         S_DIVW = 4'd4, S_STORE = 4'd5, S_CHK = 4'd6, S_MUL = 4'd7,
                         S_SQW = 4'd8, S_COMMIT = 4'd9, S_END = 4'd10, S_OUT = 4'd11;
  logic [3:0] state_q, state_d;
  logic axis_q, axis_d, far_q, far_d;
  logic ov_q, ov_d;

  assign in_ready_o  = (state_q == S_IDLE) && !ov_q;
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    far_d   = far_q;
    ov_d    = ov_q;
    cmd_o   = '{op: sbch_pkg::OP_NONE, axis: axis_q, far: far_q};
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !ov_q) begin
          cmd_o.op = sbch_pkg::OP_LOAD;
          state_d  = S_LOAD;
        end
      end
      S_LOAD: begin
        axis_d  = 1'b0;
        far_d   = 1'b0;
        state_d = sts_i.skip ? S_END : S_SLAB;
      end
      S_SLAB: begin
        cmd_o.op = axis_q ? sbch_pkg::OP_SLAB_Y : sbch_pkg::OP_SLAB_X;
        state_d  = S_DIVS;
      end
      S_DIVS: begin
        if (sts_i.par) begin
          if (sts_i.par_miss) state_d = S_END;
          else if (axis_q) state_d = S_CHK;
          else begin
            axis_d  = 1'b1;
            state_d = S_SLAB;
          end
        end else begin
          cmd_o.op = sbch_pkg::OP_DIV;
          state_d  = S_DIVW;
        end
      end
      S_DIVW: begin
        if (sts_i.div_done) begin
          cmd_o.op = far_q ? sbch_pkg::OP_TF : sbch_pkg::OP_TN;
          state_d  = S_STORE;
        end
      end
      S_STORE: begin
        if (!far_q) begin
          far_d   = 1'b1;
          state_d = S_DIVS;
        end else begin
          far_d = 1'b0;
          if (sts_i.miss) state_d = S_END;
          else if (axis_q) state_d = S_CHK;
          else begin
            axis_d  = 1'b1;
            state_d = S_SLAB;
          end
        end
      end
      S_CHK: begin
        if (sts_i.better) begin
          cmd_o.op = sbch_pkg::OP_MUL;
          state_d  = S_MUL;
        end else state_d = S_END;
      end
      S_MUL: begin
        cmd_o.op = sbch_pkg::OP_SQRT;
        state_d  = S_SQW;
      end
      S_SQW: begin
        if (sts_i.sqrt_done) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.op = sbch_pkg::OP_COMMIT;
        state_d  = S_END;
      end
      S_END: begin
        if (sts_i.last) begin
          cmd_o.op = sbch_pkg::OP_EMIT;
          state_d  = S_OUT;
        end else state_d = S_IDLE;
      end
      S_OUT: begin
        cmd_o.op = sbch_pkg::OP_CLEAR;
        ov_d     = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= 1'b0;
      far_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      far_q   <= far_d;
      ov_q    <= ov_d;
    end
  end
endmodule
`default_nettype wire

@@ rtl/sbch_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sbch_dp #(
  parameter int unsigned FRAC_BITS = sbch_pkg::FRAC_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [sbch_pkg::IN_W-1:0] in_data_i,
  input  wire logic                      in_last_i,
  input  wire sbch_pkg::cmd_t            cmd_i,
  output sbch_pkg::sts_t                 sts_o,
  output logic [sbch_pkg::OUT_W-1:0]     out_data_o,
  output logic                           out_hit_o
);
  localparam int unsigned FW = FRAC_BITS + 2;   // fraction incl. sign/overflow
  localparam int unsigned NW = 34;              // |numerator| bits
  localparam int unsigned QW = NW + FRAC_BITS;  // dividend bits
  localparam logic signed [FW-1:0] ONE = FW'(1) <<< FRAC_BITS;
  localparam int unsigned CW = $clog2(QW + 1);
  localparam int unsigned RCW = 6;

  logic signed [31:0] sx_q, sy_q, ex_q, ey_q, cx_q, cy_q;
  logic [30:0] hx_q, hy_q;
  logic [15:0] obj_q, ign_q;
  logic last_q;
  logic signed [32:0] dx, dy, d_sel;
  logic signed [33:0] ls_sel;
  logic signed [33:0] ls_q;
  logic signed [32:0] d_q;
  logic [30:0] h_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == sbch_pkg::OP_LOAD) begin
      sx_q  <= in_data_i[31:0];
      sy_q  <= in_data_i[63:32];
      ex_q  <= in_data_i[95:64];
      ey_q  <= in_data_i[127:96];
      cx_q  <= in_data_i[159:128];
      cy_q  <= in_data_i[191:160];
      hx_q  <= in_data_i[222:192];
      hy_q  <= in_data_i[253:223];
      obj_q <= in_data_i[269:254];
      ign_q <= in_data_i[285:270];
      last_q <= in_last_i;
    end
  end

  assign dx = 33'(ex_q) - 33'(sx_q);
  assign dy = 33'(ey_q) - 33'(sy_q);
  assign d_sel  = (cmd_i.op == sbch_pkg::OP_SLAB_Y) ? dy : dx;
  assign ls_sel = (cmd_i.op == sbch_pkg::OP_SLAB_Y) ? (34'(sy_q) - 34'(cy_q))
                                                    : (34'(sx_q) - 34'(cx_q));

  // numerator of current slab parameter
  logic signed [34:0] h_ext, ls_ext, num;
  logic [34:0] ls_abs;
  assign h_ext  = 35'($signed({1'b0, h_q}));
  assign ls_ext = 35'(ls_q);
  always_comb begin
    if (d_q > 0) num = cmd_i.far ? (h_ext - ls_ext) : (-h_ext - ls_ext);
    else         num = cmd_i.far ? (ls_ext + h_ext) : (ls_ext - h_ext);
  end
  assign ls_abs = ls_ext[34] ? 35'(-ls_ext) : 35'(ls_ext);

  // serial restoring divider
  logic [QW-1:0] quo_q;
  logic [33:0] rem_q;
  logic [32:0] den_q;
  logic [CW-1:0] dcnt_q;
  logic dbusy_q, neg_q;
  logic [34:0] rsh;
  assign rsh = {rem_q, quo_q[QW-1]};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.op == sbch_pkg::OP_DIV) begin
      dbusy_q <= !num[34];
      dcnt_q  <= CW'(QW);
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q - 1'b1;
      if (dcnt_q == CW'(1)) dbusy_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == sbch_pkg::OP_DIV) begin
      quo_q <= {num[NW-1:0], {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      den_q <= d_q[32] ? 33'(-d_q) : 33'(d_q);
      neg_q <= num[34];
    end else if (dbusy_q) begin
      if (rsh >= {2'b0, den_q}) begin
        rem_q <= 34'(rsh - {2'b0, den_q});
        quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= rsh[33:0];
        quo_q <= {quo_q[QW-2:0], 1'b0};
      end
    end
  end
  logic signed [FW-1:0] qv;
  always_comb begin
    if (neg_q) qv = -FW'(1);
    else if (quo_q > QW'(ONE) + QW'(1)) qv = ONE + FW'(1);
    else qv = FW'(quo_q);
  end

  // slab state
  logic signed [FW-1:0] tmin_q, tmax_q;
  logic [2:0] nrm_q;
  logic miss_q;
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      sbch_pkg::OP_LOAD: begin
        tmin_q <= '0;
        tmax_q <= ONE;
        nrm_q  <= sbch_pkg::NRM_NONE;
      end
      sbch_pkg::OP_SLAB_X, sbch_pkg::OP_SLAB_Y: begin
        ls_q <= ls_sel;
        d_q  <= d_sel;
        h_q  <= (cmd_i.op == sbch_pkg::OP_SLAB_Y) ? hy_q : hx_q;
      end
      sbch_pkg::OP_TN: begin
        if (qv > tmin_q) begin
          tmin_q <= qv;
          if (cmd_i.axis)
            nrm_q <= (h_q != 0 && d_q > 0) ? sbch_pkg::NRM_NY : sbch_pkg::NRM_PY;
          else
            nrm_q <= (h_q != 0 && d_q > 0) ? sbch_pkg::NRM_NX : sbch_pkg::NRM_PX;
        end
      end
      sbch_pkg::OP_TF: begin
        if (qv < tmax_q) tmax_q <= qv;
      end
      default: ;
    endcase
  end
  assign miss_q = tmin_q > tmax_q;

  // best state
  logic signed [FW-1:0] best_f_q;
  logic found_q;
  logic [15:0] best_o_q;
  logic [2:0] best_n_q;
  logic [31:0] best_px_q, best_py_q;
  logic [33:0] best_d_q;

  // products, registered
  logic signed [49+FW:0] px_q, py_q;
  logic [65:0] sqx_q, sqy_q, n2_q;
  logic [32:0] adx, ady;
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == sbch_pkg::OP_MUL) begin
      px_q  <= (50+FW)'(dx) * (50+FW)'(tmin_q);
      py_q  <= (50+FW)'(dy) * (50+FW)'(tmin_q);
      sqx_q <= 66'(adx) * 66'(adx);
      sqy_q <= 66'(ady) * 66'(ady);
    end
  end

  // serial integer square root, one bit per cycle
  logic [34:0] root_q;
  logic [RCW-1:0] rcnt_q;
  logic sbusy_q, sdone_q;
  logic [34:0] cand;
  logic [69:0] csq;
  assign cand = root_q | (35'(1) << rcnt_q);
  assign csq  = 70'(cand) * 70'(cand);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbusy_q <= 1'b0;
      sdone_q <= 1'b0;
      rcnt_q  <= '0;
    end else begin
      sdone_q <= 1'b0;
      if (cmd_i.op == sbch_pkg::OP_SQRT) begin
        sbusy_q <= 1'b1;
        rcnt_q  <= RCW'(34);
      end else if (sbusy_q) begin
        rcnt_q <= rcnt_q - 1'b1;
        if (rcnt_q == '0) begin
          sbusy_q <= 1'b0;
          sdone_q <= 1'b1;
        end
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == sbch_pkg::OP_SQRT) begin
      root_q <= '0;
      n2_q   <= sqx_q + sqy_q;
    end else if (sbusy_q && csq <= 70'(n2_q)) root_q <= cand;
  end

  logic [34+FW:0] dist_full;
  assign dist_full = (35+FW)'(root_q) * (35+FW)'(tmin_q);
  logic signed [49+FW:0] fx, fy;
  assign fx = px_q >>> FRAC_BITS;
  assign fy = py_q >>> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q  <= 1'b0;
      best_f_q <= ONE;
      best_o_q <= '0;
      best_n_q <= '0;
      best_px_q <= '0;
      best_py_q <= '0;
      best_d_q <= '0;
    end else if (cmd_i.op == sbch_pkg::OP_COMMIT) begin
      found_q  <= 1'b1;
      best_f_q <= tmin_q;
      best_o_q <= obj_q;
      best_n_q <= nrm_q;
      best_px_q <= 32'(sx_q + 32'(fx));
      best_py_q <= 32'(sy_q + 32'(fy));
      best_d_q <= 34'(dist_full >> FRAC_BITS);
    end else if (cmd_i.op == sbch_pkg::OP_CLEAR) begin
      found_q  <= 1'b0;
      best_f_q <= ONE;
      best_o_q <= '0;
      best_n_q <= '0;
      best_px_q <= '0;
      best_py_q <= '0;
      best_d_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == sbch_pkg::OP_EMIT) begin
      out_hit_o  <= found_q;
      out_data_o <= sbch_pkg::OUT_W'({best_d_q, best_py_q, best_px_q, best_n_q,
                                      16'(best_f_q), best_o_q});
    end
  end

  assign sts_o.skip      = (dx == 0 && dy == 0) || (ign_q != 0 && obj_q == ign_q);
  assign sts_o.par       = (d_q == 0);
  assign sts_o.par_miss  = ls_abs > 35'(h_q);
  assign sts_o.neg_num   = neg_q;
  assign sts_o.div_done  = !dbusy_q;
  assign sts_o.miss      = miss_q;
  assign sts_o.better    = !miss_q && (tmin_q < best_f_q);
  assign sts_o.sqrt_done = sdone_q;
  assign sts_o.last      = last_q;
endmodule
`default_nettype wire

@@ rtl/segment_box_closest_hit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | payload
// s_axis  | in  | tdata: start_x,start_y,end_x,end_y,center_x,center_y,half_x,half_y,
//         |     |        object_id,ignore_id; tlast: last
// m_axis  | out | tdata: hit_object,fraction,normal,point_x,point_y,distance; tuser: hit
// One box per beat. Each slab division runs in the shared serial divider; a negative
// numerator needs no divide. The root runs only when a closer hit is found. A skipped
// box goes from load straight to the end state. The worst case runs two axes, four
// divides and the root; a last beat also loads the result. Reset is asynchronous,
// active low. A result beat stalled at m_axis blocks the next input beat.
module segment_box_closest_hit #(
  parameter int unsigned FRAC_BITS = sbch_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [sbch_pkg::IN_W-1:0]  s_axis_tdata,  // start_x..ignore_id low up
  input  wire logic                       s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [sbch_pkg::OUT_W-1:0]      m_axis_tdata,  // hit_object..distance low up
  output logic                            m_axis_tuser   // hit
);
  sbch_pkg::cmd_t cmd;
  sbch_pkg::sts_t sts;

  sbch_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  sbch_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni,
    .in_data_i(s_axis_tdata), .in_last_i(s_axis_tlast),
    .cmd_i(cmd), .sts_o(sts),
    .out_data_o(m_axis_tdata), .out_hit_o(m_axis_tuser)
  );
endmodule
`default_nettype wire

@@ rtl/sbch_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "segment_box_closest_hit_assert.svh"
module sbch_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic m_axis_tuser
);
  `SBCH_ASSERT(a_no_in_while_out, clk_i, rst_ni, m_axis_tvalid |-> !s_axis_tready)
  `SBCH_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `SBCH_ASSERT(a_in_gap, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  `SBCH_ASSERT_NR(a_reset_idle, clk_i, !rst_ni |-> !m_axis_tvalid)
endmodule
bind segment_box_closest_hit sbch_checker u_chk (.*);
`default_nettype wire
